### src/s2rgb_pkg.sv
// Shared types, constants and elaboration-time helpers for the scalar to RGB16 colormap.
// No dependencies.
package s2rgb_pkg;

   localparam int LOG2_FRAC  = 20;
   localparam int LOG2_INT_W = 7;
   localparam int LOG2_W     = LOG2_INT_W + LOG2_FRAC;
   localparam int POW_STEPS  = 20;
   localparam int LN_W       = 24;
   localparam int BASE_W     = 50;
   localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;

   typedef enum logic [1:0] {
      MODE_LINEAR = 2'd0,
      MODE_LOG    = 2'd1,
      MODE_POW    = 2'd2,
      MODE_SPARE  = 2'd3
   } map_mode_type;

   typedef enum logic [1:0] {
      SCHEME_RED  = 2'd0,
      SCHEME_BLUE = 2'd1,
      SCHEME_GRAY = 2'd2,
      SCHEME_INV  = 2'd3
   } scheme_type;

   typedef enum logic [2:0] {
      CSR_MAP_MODE = 3'd0,
      CSR_SCHEME   = 3'd1,
      CSR_EXPONENT = 3'd2,
      CSR_OFFSET   = 3'd3,
      CSR_GAIN     = 3'd4
   } csr_index_type;

   typedef struct packed {
      map_mode_type       map_mode;
      scheme_type         color_scheme;
      logic signed [15:0] exponent;
      logic signed [31:0] offset;
      logic signed [31:0] gain;
   } cfg_type;

   // bitwise integer square root, elaboration use only
   function automatic logic [63:0] isqrt64(input logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = xin;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(2^-idx) in Q.30, idx from 1
   function automatic logic [30:0] pow_factor(input int idx);
      logic [63:0] c;
      c = isqrt64(64'd2 << 60);
      for (int i = 1; i < idx; i++) begin
         c = isqrt64(c << 30);
      end
      return c[30:0];
   endfunction

endpackage

### src/s2rgb_log2.sv
// log2 unit: leading-one stage then one squaring stage per fraction bit.
// Depends on s2rgb_pkg.
module s2rgb_log2
   import s2rgb_pkg::*;
#(
   parameter int VALUE_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic [31:0]              in_raw,
   output logic                     out_valid,
   output logic [31:0]              out_raw,
   output logic                     out_zero,
   output logic signed [LOG2_W-1:0] out_log2
);

   logic                         valid_ff [0:LOG2_FRAC];
   logic [31:0]                  raw_ff   [0:LOG2_FRAC];
   logic                         zero_ff  [0:LOG2_FRAC];
   logic [31:0]                  x_ff     [0:LOG2_FRAC];
   logic [LOG2_FRAC-1:0]         frac_ff  [0:LOG2_FRAC];
   logic signed [LOG2_INT_W-1:0] int_ff   [0:LOG2_FRAC];

   logic [4:0]  lead_in;
   logic [31:0] x_in;
   logic signed [LOG2_INT_W-1:0] int_in;

   always_comb begin
      lead_in = '0;
      for (int b = 0; b < 32; b++) begin
         if (in_raw[b]) lead_in = 5'(b);
      end
      x_in   = in_raw << (5'd31 - lead_in);
      int_in = LOG2_INT_W'($signed({2'b00, lead_in}) - VALUE_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         raw_ff[0]  <= in_raw;
         zero_ff[0] <= (in_raw == '0);
         x_ff[0]    <= x_in;
         frac_ff[0] <= '0;
         int_ff[0]  <= int_in;
      end
   end

   for (genvar j = 1; j <= LOG2_FRAC; j++) begin : g_sq
      localparam logic [LOG2_FRAC-1:0] FBIT = LOG2_FRAC'(1) << (LOG2_FRAC - j);
      logic [63:0] sq;
      assign sq = {32'b0, x_ff[j-1]} * {32'b0, x_ff[j-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            raw_ff[j]  <= raw_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
            int_ff[j]  <= int_ff[j-1];
            // square in Q2.62; a carry into 2.0 halves it and sets the bit
            x_ff[j]    <= sq[63] ? sq[63:32] : sq[62:31];
            frac_ff[j] <= frac_ff[j-1] | (sq[63] ? FBIT : '0);
         end
      end
   end

   assign out_valid = valid_ff[LOG2_FRAC];
   assign out_raw   = raw_ff[LOG2_FRAC];
   assign out_zero  = zero_ff[LOG2_FRAC];
   assign out_log2  = $signed({int_ff[LOG2_FRAC], frac_ff[LOG2_FRAC]});

endmodule

### src/s2rgb_pow.sv
// Mapping unit: ln and exponent products, exp2 by constant factors, base selection.
// Depends on s2rgb_pkg.
module s2rgb_pow
   import s2rgb_pkg::*;
#(
   parameter int VALUE_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  cfg_type                  cfg,
   input  logic                     in_valid,
   input  logic [31:0]              in_raw,
   input  logic                     in_zero,
   input  logic signed [LOG2_W-1:0] in_log2,
   output logic                     out_valid,
   output logic signed [BASE_W-1:0] out_base
);

   logic                   valid_ff [0:POW_STEPS];
   logic [31:0]            raw_ff   [0:POW_STEPS];
   logic                   zero_ff  [0:POW_STEPS];
   logic signed [LN_W-1:0] ln_ff    [0:POW_STEPS];
   logic signed [14:0]     n_ff     [0:POW_STEPS];
   logic [27:0]            f_ff     [0:POW_STEPS];
   logic [30:0]            p_ff     [0:POW_STEPS];

   logic signed [57:0] ln_prod;
   logic signed [42:0] y_prod;

   assign ln_prod = 58'(in_log2) * 58'(LN2_Q30);
   assign y_prod  = 43'(cfg.exponent) * 43'(in_log2);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         raw_ff[0]  <= in_raw;
         zero_ff[0] <= in_zero;
         ln_ff[0]   <= ln_prod[57:34];
         n_ff[0]    <= y_prod[42:28];
         f_ff[0]    <= y_prod[27:0];
         p_ff[0]    <= 31'd1 << 30;
      end
   end

   for (genvar j = 1; j <= POW_STEPS; j++) begin : g_exp
      localparam logic [30:0] FACTOR = pow_factor(j);
      logic [61:0] prod;
      assign prod = {31'b0, p_ff[j-1]} * {31'b0, FACTOR};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (enable) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            raw_ff[j]  <= raw_ff[j-1];
            zero_ff[j] <= zero_ff[j-1];
            ln_ff[j]   <= ln_ff[j-1];
            n_ff[j]    <= n_ff[j-1];
            f_ff[j]    <= f_ff[j-1];
            p_ff[j]    <= f_ff[j-1][28-j] ? prod[60:30] : p_ff[j-1];
         end
      end
   end

   localparam logic [48:0] POW_SAT = 49'd1 << 48;

   logic [48:0]              pow_in;
   logic signed [BASE_W-1:0] lin_in;
   logic signed [BASE_W-1:0] base_in;
   logic signed [14:0]       n_cur;
   logic                     valid_out_ff;
   logic signed [BASE_W-1:0] base_ff;

   always_comb begin
      n_cur = n_ff[POW_STEPS];
      if (zero_ff[POW_STEPS]) begin
         if (cfg.exponent > 0)       pow_in = '0;
         else if (cfg.exponent == 0) pow_in = 49'd65536;
         else                        pow_in = POW_SAT;
      end else if (n_cur >= 15'sd32) begin
         pow_in = POW_SAT;
      end else if (n_cur < -15'sd17) begin
         pow_in = '0;
      end else if (n_cur >= 15'sd14) begin
         pow_in = 49'(p_ff[POW_STEPS]) << 5'(n_cur - 15'sd14);
      end else begin
         pow_in = 49'(p_ff[POW_STEPS]) >> 5'(15'sd14 - n_cur);
      end

      if (VALUE_FRAC_BITS >= 16) begin
         lin_in = BASE_W'(raw_ff[POW_STEPS]) >> (VALUE_FRAC_BITS - 16);
      end else begin
         lin_in = BASE_W'(raw_ff[POW_STEPS]) << (16 - VALUE_FRAC_BITS);
      end

      unique case (cfg.map_mode)
         MODE_LOG: base_in = zero_ff[POW_STEPS] ? -(BASE_W'(1) <<< 31)
                                                : BASE_W'(ln_ff[POW_STEPS]);
         MODE_POW: base_in = $signed(BASE_W'(pow_in));
         default:  base_in = lin_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else if (enable) begin
         valid_out_ff <= valid_ff[POW_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) base_ff <= base_in;
   end

   assign out_valid = valid_out_ff;
   assign out_base  = base_ff;

endmodule

### src/s2rgb_gain.sv
// Offset add, sign-magnitude gain multiply in two partial products, truncate and saturate.
// Depends on s2rgb_pkg.
module s2rgb_gain
   import s2rgb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  cfg_type                  cfg,
   input  logic                     in_valid,
   input  logic signed [BASE_W-1:0] in_base,
   output logic                     out_valid,
   output logic signed [31:0]       out_inten
);

   logic [3:0] valid_ff;

   logic signed [BASE_W:0] sum_ff;
   logic                   neg_ff;
   logic [BASE_W-1:0]      ua_ff;
   logic [31:0]            ub_ff;
   logic                   neg2_ff;
   logic [56:0]            pp_hi_ff;
   logic [56:0]            pp_lo_ff;
   logic signed [31:0]     inten_ff;

   logic [BASE_W:0] sum_abs;
   logic [32:0]     gain_abs;
   logic [81:0]     full;
   logic [65:0]     q;
   logic signed [31:0] inten_in;

   always_comb begin
      sum_abs  = sum_ff[BASE_W] ? (BASE_W+1)'(-sum_ff) : (BASE_W+1)'(sum_ff);
      gain_abs = cfg.gain[31] ? 33'(-33'(cfg.gain)) : 33'(cfg.gain);
      full     = {pp_hi_ff, 25'b0} + 82'(pp_lo_ff);
      q        = full[81:16];
      if (neg2_ff) begin
         if (q >= 66'h8000_0000) inten_in = 32'sh8000_0000;
         else                    inten_in = -$signed(q[31:0]);
      end else begin
         if (q > 66'h7FFF_FFFF)  inten_in = 32'sh7FFF_FFFF;
         else                    inten_in = $signed(q[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff   <= (BASE_W+1)'(in_base) + (BASE_W+1)'(cfg.offset);
         neg_ff   <= sum_ff[BASE_W] ^ cfg.gain[31];
         ua_ff    <= sum_abs[BASE_W-1:0];
         ub_ff    <= gain_abs[31:0];
         neg2_ff  <= neg_ff;
         pp_hi_ff <= 57'(ua_ff[BASE_W-1:25]) * 57'(ub_ff);
         pp_lo_ff <= 57'(ua_ff[24:0]) * 57'(ub_ff);
         inten_ff <= inten_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_inten = inten_ff;

endmodule

### src/s2rgb_color.sv
// Color scheme and 16-bit clamp into the output register.
// Depends on s2rgb_pkg.
module s2rgb_color
   import s2rgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic signed [31:0] in_inten,
   output logic               out_valid,
   output logic [15:0]        out_red,
   output logic [15:0]        out_green,
   output logic [15:0]        out_blue
);

   function automatic logic [15:0] clamp16(input logic signed [33:0] v);
      if (v < 0)              return '0;
      else if (v > 34'sd65535) return 16'hFFFF;
      else                    return v[15:0];
   endfunction

   logic signed [33:0] twice;
   logic signed [33:0] ramp;
   logic signed [33:0] inv;
   logic [15:0] red_in, green_in, blue_in;
   logic        valid_ff;
   logic [15:0] red_ff, green_ff, blue_ff;

   always_comb begin
      twice = {in_inten[31], in_inten, 1'b0};
      ramp  = twice - 34'sd65536;
      inv   = 34'sd65536 - 34'(in_inten);
      unique case (cfg.color_scheme)
         SCHEME_RED: begin
            red_in   = clamp16(twice);
            green_in = clamp16(ramp);
            blue_in  = '0;
         end
         SCHEME_BLUE: begin
            red_in   = '0;
            green_in = clamp16(ramp);
            blue_in  = clamp16(twice);
         end
         SCHEME_GRAY: begin
            red_in   = clamp16(34'(in_inten));
            green_in = red_in;
            blue_in  = red_in;
         end
         default: begin
            red_in   = clamp16(inv);
            green_in = red_in;
            blue_in  = red_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

### src/scalar_to_rgb16_colormap_top.sv
// Top level of the scalar to RGB16 colormap: CSR bank, pipeline enable, unit chain.
// Depends on s2rgb_pkg, s2rgb_log2, s2rgb_pow, s2rgb_gain, s2rgb_color.
//
//   channel | dir | handshake                | payload
//   req     | in  | req_tvalid / req_tready  | req_tdata: sample_value
//   rsp     | out | rsp_tvalid / rsp_tready  | rsp_tdata: red, green, blue
//   csr     | in  | csr_valid / csr_ready    | csr_index, csr_data
//
// One item per cycle while the output is taken; 21 log2 stages (20 squarings),
// 22 ln/exp2 stages (20 constant multiplies), 4 gain stages, 1 output register.
// One enable moves every stage; it drops only when the output item is not taken,
// so nothing is lost or repeated. Reset (synchronous) clears the valid bits and
// loads the register defaults. csr writes are always accepted.
module scalar_to_rgb16_colormap_top
   import s2rgb_pkg::*;
#(
   parameter int VALUE_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] red, [31:16] green, [47:32] blue
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type cfg_ff;
   logic    enable;

   // chain advances unless a finished item waits at the output
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_mode     <= MODE_LINEAR;
         cfg_ff.color_scheme <= SCHEME_RED;
         cfg_ff.exponent     <= 16'sd256;
         cfg_ff.offset       <= '0;
         cfg_ff.gain         <= 32'sd65536;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAP_MODE: cfg_ff.map_mode     <= map_mode_type'(csr_data[1:0]);
            CSR_SCHEME:   cfg_ff.color_scheme <= scheme_type'(csr_data[1:0]);
            CSR_EXPONENT: cfg_ff.exponent     <= $signed(csr_data[15:0]);
            CSR_OFFSET:   cfg_ff.offset       <= $signed(csr_data);
            CSR_GAIN:     cfg_ff.gain         <= $signed(csr_data);
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   logic                     lg_valid;
   logic [31:0]              lg_raw;
   logic                     lg_zero;
   logic signed [LOG2_W-1:0] lg_log2;
   logic                     base_valid;
   logic signed [BASE_W-1:0] base;
   logic                     int_valid;
   logic signed [31:0]       inten;

   s2rgb_log2 #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_log2 (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(req_tvalid), .in_raw(req_tdata),
      .out_valid(lg_valid), .out_raw(lg_raw), .out_zero(lg_zero), .out_log2(lg_log2)
   );

   s2rgb_pow #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_pow (
      .clock(clock), .reset(reset), .enable(enable), .cfg(cfg_ff),
      .in_valid(lg_valid), .in_raw(lg_raw), .in_zero(lg_zero), .in_log2(lg_log2),
      .out_valid(base_valid), .out_base(base)
   );

   s2rgb_gain u_gain (
      .clock(clock), .reset(reset), .enable(enable), .cfg(cfg_ff),
      .in_valid(base_valid), .in_base(base),
      .out_valid(int_valid), .out_inten(inten)
   );

   s2rgb_color u_color (
      .clock(clock), .reset(reset), .enable(enable), .cfg(cfg_ff),
      .in_valid(int_valid), .in_inten(inten),
      .out_valid(rsp_tvalid), .out_red(rsp_tdata[15:0]),
      .out_green(rsp_tdata[31:16]), .out_blue(rsp_tdata[47:32])
   );

endmodule
